>>> rtl/zobrist_position_hash_assert.svh
// assertion macros for the zobrist position hash block
`ifndef ZOBRIST_POSITION_HASH_ASSERT_SVH
`define ZOBRIST_POSITION_HASH_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define ZPH_ASSERT_IMP(name, clk_i, rstn_i, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
    else $error("zph assertion failed");

// next-cycle implication, disabled while reset is low
`define ZPH_ASSERT_NXT(name, clk_i, rstn_i, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
    else $error("zph assertion failed");

`endif

>>> rtl/zph_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package zph_pkg;

  // default geometry
  localparam int SQUARES_DEF     = 64;
  localparam int PIECE_TYPES_DEF = 6;
  localparam int BOARD_BITS      = 64;
  localparam int KEY_W           = 64;
  localparam int SCAN_W          = $clog2(BOARD_BITS);

  // item kinds
  typedef enum logic [2:0] {
    KIND_LOAD_TABLE = 3'd0,
    KIND_LOAD_SIDE  = 3'd1,
    KIND_BOARD      = 3'd2,
    KIND_TOGGLE     = 3'd3,
    KIND_PREDICT    = 3'd4
  } kind_t;

  // table read source
  typedef enum logic [1:0] {
    SEL_SCAN = 2'd0,
    SEL_FROM = 2'd1,
    SEL_TO   = 2'd2,
    SEL_CAP  = 2'd3
  } sel_t;

  // input beat
  typedef struct packed {
    logic [2:0]       kind;
    logic             color;
    logic [2:0]       piece;
    logic [5:0]       from_square;
    logic [5:0]       to_square;
    logic [2:0]       captured_piece;
    logic [KEY_W-1:0] value;
    logic             last;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             is_prediction;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic wr_table;
    logic wr_side;
    logic toggle;
    logic scan_clr;
    logic scan_inc;
    logic rd_en;
    sel_t sel;
    logic dst_pred;
    logic pred_init;
    logic board_end;
    logic emit_pred;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic scan_done;
  } status_t;

endpackage

`default_nettype wire

>>> rtl/zph_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module zph_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [2:0]        in_kind,
  input  zph_pkg::status_t  status,
  output zph_pkg::cmd_t     cmd,
  output logic              busy
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_BDRAIN,
    S_BEND,
    S_PFROM,
    S_PTO,
    S_PCAP,
    S_PDRAIN,
    S_PEND
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   busy_r;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.sel   = zph_pkg::SEL_SCAN;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (in_kind)
            zph_pkg::KIND_LOAD_TABLE: cmd.wr_table = 1'b1;
            zph_pkg::KIND_LOAD_SIDE:  cmd.wr_side  = 1'b1;
            zph_pkg::KIND_TOGGLE:     cmd.toggle   = 1'b1;
            zph_pkg::KIND_BOARD: begin
              cmd.capture  = 1'b1;
              cmd.scan_clr = 1'b1;
              state_nxt    = S_SCAN;
            end
            zph_pkg::KIND_PREDICT: begin
              cmd.capture = 1'b1;
              state_nxt   = S_PFROM;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        cmd.rd_en    = 1'b1;
        cmd.sel      = zph_pkg::SEL_SCAN;
        cmd.scan_inc = 1'b1;
        if (status.scan_done) begin
          state_nxt = S_BDRAIN;
        end
      end
      S_BDRAIN: state_nxt = S_BEND;
      S_BEND: begin
        cmd.board_end = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_PFROM: begin
        cmd.pred_init = 1'b1;
        cmd.rd_en     = 1'b1;
        cmd.sel       = zph_pkg::SEL_FROM;
        cmd.dst_pred  = 1'b1;
        state_nxt     = S_PTO;
      end
      S_PTO: begin
        cmd.rd_en    = 1'b1;
        cmd.sel      = zph_pkg::SEL_TO;
        cmd.dst_pred = 1'b1;
        state_nxt    = S_PCAP;
      end
      S_PCAP: begin
        cmd.rd_en    = 1'b1;
        cmd.sel      = zph_pkg::SEL_CAP;
        cmd.dst_pred = 1'b1;
        state_nxt    = S_PDRAIN;
      end
      S_PDRAIN: state_nxt = S_PEND;
      S_PEND: begin
        cmd.emit_pred = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and busy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

`default_nettype wire

>>> rtl/zph_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module zph_datapath #(
  parameter int SQUARES     = zph_pkg::SQUARES_DEF,
  parameter int PIECE_TYPES = zph_pkg::PIECE_TYPES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  zph_pkg::in_item_t  in_item,
  input  zph_pkg::cmd_t      cmd,
  output zph_pkg::status_t   status,
  output logic               out_valid,
  output zph_pkg::out_item_t out_item
);

  localparam int TABLE_DEPTH = 2 * PIECE_TYPES * SQUARES;
  localparam int AW          = $clog2(TABLE_DEPTH);
  localparam int SCAN_LAST   =
    ((SQUARES < zph_pkg::BOARD_BITS) ? SQUARES : zph_pkg::BOARD_BITS) - 1;

  // word is present only for a real piece on a square inside the board
  function automatic logic slot_ok(input logic [2:0] p, input logic [5:0] s);
    slot_ok = (p != 3'd0) && (int'(p) <= PIECE_TYPES) && (int'(s) < SQUARES);
  endfunction

  // row is color then piece, column is square
  function automatic logic [AW-1:0] slot_addr(input logic c, input logic [2:0] p,
                                              input logic [5:0] s);
    slot_addr = AW'((int'(c) * PIECE_TYPES + int'(p) - 1) * SQUARES + int'(s));
  endfunction

  logic [zph_pkg::KEY_W-1:0]  mem [TABLE_DEPTH];
  zph_pkg::in_item_t          item_r;
  logic [zph_pkg::SCAN_W-1:0] scan_r;
  logic [zph_pkg::KEY_W-1:0]  rd_data_r;
  logic                       rd_ok_r;
  logic                       dst_pred_r;
  logic [zph_pkg::KEY_W-1:0]  side_r;
  logic [zph_pkg::KEY_W-1:0]  key_r;
  logic [zph_pkg::KEY_W-1:0]  acc_r;
  logic [zph_pkg::KEY_W-1:0]  pred_r;
  logic                       out_valid_r;
  zph_pkg::out_item_t         out_item_r;

  logic                       rd_c;
  logic [2:0]                 rd_p;
  logic [5:0]                 rd_s;
  logic                       rd_bit;
  logic                       rd_ok;
  logic [AW-1:0]              rd_addr;
  logic                       wr_ok;
  logic [AW-1:0]              wr_addr;
  logic [zph_pkg::KEY_W-1:0]  rd_word;

  // read source select
  always_comb begin
    rd_c   = item_r.color;
    rd_p   = item_r.piece;
    rd_s   = item_r.from_square;
    rd_bit = 1'b1;
    unique case (cmd.sel)
      zph_pkg::SEL_SCAN: begin
        rd_s   = 6'(scan_r);
        rd_bit = item_r.value[scan_r];
      end
      zph_pkg::SEL_FROM: rd_s = item_r.from_square;
      zph_pkg::SEL_TO:   rd_s = item_r.to_square;
      zph_pkg::SEL_CAP: begin
        rd_c = ~item_r.color;
        rd_p = item_r.captured_piece;
        rd_s = item_r.to_square;
      end
      default: ;
    endcase
    rd_ok   = rd_bit && slot_ok(rd_p, rd_s);
    rd_addr = rd_ok ? slot_addr(rd_c, rd_p, rd_s) : '0;
    wr_ok   = slot_ok(in_item.piece, in_item.from_square);
    wr_addr = wr_ok ? slot_addr(in_item.color, in_item.piece, in_item.from_square) : '0;
  end

  // table memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_table && wr_ok) begin
      mem[wr_addr] <= in_item.value;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_word = rd_ok_r ? rd_data_r : '0;

  // read pipeline tags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ok_r    <= 1'b0;
      dst_pred_r <= 1'b0;
    end else begin
      rd_ok_r    <= cmd.rd_en && rd_ok;
      dst_pred_r <= cmd.dst_pred;
    end
  end

  // item capture, square counter, side word, prediction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_item;
    end
    if (cmd.scan_clr) begin
      scan_r <= '0;
    end else if (cmd.scan_inc) begin
      scan_r <= scan_r + 1'b1;
    end
    if (cmd.wr_side) begin
      side_r <= in_item.value;
    end
    if (cmd.pred_init) begin
      pred_r <= key_r ^ side_r;
    end else if (dst_pred_r) begin
      pred_r <= pred_r ^ rd_word;
    end
  end

  assign status.scan_done = (scan_r == zph_pkg::SCAN_W'(SCAN_LAST));

  // current key and board accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
      acc_r <= '0;
    end else begin
      if (cmd.toggle) begin
        key_r <= key_r ^ side_r;
      end else if (cmd.board_end && item_r.last) begin
        key_r <= acc_r;
      end
      if (cmd.board_end && item_r.last) begin
        acc_r <= '0;
      end else if (!dst_pred_r) begin
        acc_r <= acc_r ^ rd_word;
      end
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.board_end && item_r.last) || cmd.emit_pred;
    end
    out_item_r.key           <= cmd.emit_pred ? pred_r : acc_r;
    out_item_r.is_prediction <= cmd.emit_pred;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

>>> rtl/zobrist_position_hash.sv
// board beat: busy through the scan, drain and end states, one table read per square
// predict beat: busy through the from, to, capture, drain and end states, three table reads on the single read port
// load and toggle beats are done in the idle state and leave busy low
// a result strobes out_valid one cycle, in the same cycle that busy falls
// rst_n is synchronous: clears key, accumulator and control; table and side word keep
// their contents, undefined until loaded, with no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module zobrist_position_hash #(
  parameter int SQUARES     = zph_pkg::SQUARES_DEF,
  parameter int PIECE_TYPES = zph_pkg::PIECE_TYPES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  zph_pkg::in_item_t  in_item,
  output logic               busy,
  output logic               out_valid,
  output zph_pkg::out_item_t out_item
);

  zph_pkg::cmd_t    cmd;
  zph_pkg::status_t status;
  logic             board_beat;

  // sequencer
  zph_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_item.kind),
    .status  (status),
    .cmd     (cmd),
    .busy    (busy)
  );

  // table, key registers and result
  zph_datapath #(
    .SQUARES     (SQUARES),
    .PIECE_TYPES (PIECE_TYPES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // board beat taken this cycle
  assign board_beat = start && !busy && (in_item.kind == zph_pkg::KIND_BOARD);

  // checks
`include "zobrist_position_hash_assert.svh"

  `ZPH_ASSERT_NXT(a_single_strobe, clk, rst_n, out_valid, !out_valid)
  `ZPH_ASSERT_IMP(a_result_when_idle, clk, rst_n, out_valid, !busy && $past(busy))
  `ZPH_ASSERT_NXT(a_board_goes_busy, clk, rst_n, board_beat, busy)
  `ZPH_ASSERT_IMP(a_no_read_when_idle, clk, rst_n, !busy, !cmd.rd_en)

endmodule

`default_nettype wire
